// File: design/pmma_pkg.sv
// ----------------------------------------------------------------------------
// pmma_pkg: shared types and constants of the polyhedron mass moment core
// Holds the internal widths, the accumulator slot numbers and the structs that
// pass between the front end, the item queue and the accumulation back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmma_pkg;

  // Field width of one coordinate on the ports, and the default live width.
  localparam int CoordW        = 12;
  localparam int CoordWidthDef = 12;

  // Internal widths, sized for the largest coordinate width.
  localparam int SumW   = CoordW + 2;          // sum of three vertices
  localparam int CrossW = 2 * CoordW + 1;      // one cross product component
  localparam int DetW   = 37;                  // |det| < 2^36
  localparam int FacW   = 27;                  // |covariance factor| < 2^26
  localparam int AccW   = 64;

  // Accumulator slots, in result order.
  localparam int NumAcc  = 10;
  localparam int AccIdxW = $clog2(NumAcc);

  localparam logic [AccIdxW-1:0] AccCovXx = AccIdxW'(0);
  localparam logic [AccIdxW-1:0] AccCovYy = AccIdxW'(1);
  localparam logic [AccIdxW-1:0] AccCovZz = AccIdxW'(2);
  localparam logic [AccIdxW-1:0] AccCovXy = AccIdxW'(3);
  localparam logic [AccIdxW-1:0] AccCovXz = AccIdxW'(4);
  localparam logic [AccIdxW-1:0] AccCovYz = AccIdxW'(5);
  localparam logic [AccIdxW-1:0] AccDet   = AccIdxW'(6);
  localparam logic [AccIdxW-1:0] AccMomX  = AccIdxW'(7);
  localparam logic [AccIdxW-1:0] AccMomY  = AccIdxW'(8);
  localparam logic [AccIdxW-1:0] AccMomZ  = AccIdxW'(9);

  // Depth of the queue between front and back.
  localparam int QDepth = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // One classified face: vertices indexed [vertex][axis] and the vertex sums.
  typedef struct packed {
    logic                  restart;
    coord_t [2:0][2:0]     p;
    sum_t   [2:0]          s;
  } pmma_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pmma_q_stat_t;

  typedef struct packed {
    acc_t [NumAcc-1:0] acc;
    logic              overflow;
  } pmma_result_t;

endpackage

// File: design/pmma_face_if.sv
// ----------------------------------------------------------------------------
// pmma_face_if: face request channel
// Carries one hull triangle per request with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmma_face_if
  import pmma_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   restart;
  coord_t ax;
  coord_t ay;
  coord_t az;
  coord_t bx;
  coord_t by;
  coord_t bz;
  coord_t cx;
  coord_t cy;
  coord_t cz;

  modport source (
    output valid, restart, ax, ay, az, bx, by, bz, cx, cy, cz,
    input  ready
  );

  modport sink (
    input  valid, restart, ax, ay, az, bx, by, bz, cx, cy, cz,
    output ready
  );
endinterface

// File: design/pmma_result_if.sv
// ----------------------------------------------------------------------------
// pmma_result_if: running totals channel
// Carries the accumulated moments of one request with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmma_result_if
  import pmma_pkg::*;
();
  logic valid;
  logic ready;
  acc_t cov_xx;
  acc_t cov_yy;
  acc_t cov_zz;
  acc_t cov_xy;
  acc_t cov_xz;
  acc_t cov_yz;
  acc_t det_total;
  acc_t moment_x;
  acc_t moment_y;
  acc_t moment_z;
  logic overflow;

  modport source (
    output valid, cov_xx, cov_yy, cov_zz, cov_xy, cov_xz, cov_yz,
           det_total, moment_x, moment_y, moment_z, overflow,
    input  ready
  );

  modport sink (
    input  valid, cov_xx, cov_yy, cov_zz, cov_xy, cov_xz, cov_yz,
           det_total, moment_x, moment_y, moment_z, overflow,
    output ready
  );
endinterface

// File: design/pmma_front.sv
// ----------------------------------------------------------------------------
// pmma_front: face intake and classification
// Accepts face requests while the queue has room, keeps the live coordinate
// bits with sign extension and forms the per-axis vertex sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmma_front
  import pmma_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  pmma_face_if.sink    face_i,
  input  pmma_q_stat_t q_stat_i,
  output logic         push_o,
  output pmma_item_t   item_o
);

  coord_t [2:0][2:0] raw;

  // Take a request whenever the queue can hold it.
  assign face_i.ready = !q_stat_i.full;
  assign push_o       = face_i.valid && !q_stat_i.full;

  assign raw[0][0] = face_i.ax;
  assign raw[0][1] = face_i.ay;
  assign raw[0][2] = face_i.az;
  assign raw[1][0] = face_i.bx;
  assign raw[1][1] = face_i.by;
  assign raw[1][2] = face_i.bz;
  assign raw[2][0] = face_i.cx;
  assign raw[2][1] = face_i.cy;
  assign raw[2][2] = face_i.cz;

  // Drop the unused upper bits, then add the three vertices on each axis.
  always_comb begin
    item_o.restart = face_i.restart;
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        item_o.p[v][k] = coord_t'($signed(raw[v][k][COORD_WIDTH-1:0]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      item_o.s[k] = sum_t'($signed(item_o.p[0][k])) + sum_t'($signed(item_o.p[1][k]))
                  + sum_t'($signed(item_o.p[2][k]));
    end
  end

endmodule

// File: design/pmma_queue.sv
// ----------------------------------------------------------------------------
// pmma_queue: short item queue between front and back
// A small first-in first-out buffer of classified faces so that intake and
// accumulation stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmma_queue
  import pmma_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pmma_item_t   item_i,
  input  logic         pop_i,
  output pmma_item_t   item_o,
  output pmma_q_stat_t stat_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  pmma_item_t            mem_q [QDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  // Storage is written on a push; no reset is needed for the payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == CntW'(0));
  assign stat_o.full  = (count_q == CntW'(QDepth));

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/pmma_back.sv
// ----------------------------------------------------------------------------
// pmma_back: triple product and saturating accumulation sequencer
// Takes one face from the queue, forms the cross product and the triple
// product, then walks the ten accumulators through a factor, multiply and
// saturating add pipeline before loading the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmma_back
  import pmma_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pmma_item_t   item_i,
  input  pmma_q_stat_t q_stat_i,
  output logic         pop_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output pmma_result_t res_o
);

  localparam int CntW = $clog2(NumAcc + 2);
  localparam logic [CntW-1:0] CntLast = CntW'(NumAcc + 1);

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StCross = 5'b00010,
    StDet   = 5'b00100,
    StRun   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  typedef logic signed [2*CoordW-1:0]      prod_t;
  typedef logic signed [CrossW-1:0]        cross_t;
  typedef logic signed [CoordW+CrossW-1:0] dot_t;
  typedef logic signed [DetW-1:0]          det_t;
  typedef logic signed [FacW-1:0]          fac_t;
  typedef logic signed [2*SumW-1:0]        ssq_t;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  pmma_item_t          item_q;
  cross_t [2:0]        cross_q, cross_d;
  det_t                det_q, det_d;
  fac_t                fac_q, fac_d;
  logic [AccIdxW-1:0]  fac_idx_q, fac_idx_d;
  logic                fac_vld_q, fac_vld_d;
  acc_t                term_q, term_d;
  logic [AccIdxW-1:0]  term_idx_q;
  logic                term_vld_q;
  acc_t                acc_q [NumAcc];
  logic                ovf_q;
  pmma_result_t        res_q;
  logic                res_vld_q;
  logic                load_res;

  prod_t               cp [6];
  dot_t                dp [3];
  logic [1:0]          ax_r, ax_c;
  prod_t               pp0, pp1, pp2;
  ssq_t                ssq;
  fac_t                cov_fac;
  logic signed [AccW:0] wide_sum;
  acc_t                sat_val;
  logic                sat_hit;

  // Sequencer control.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pop_o    = 1'b0;
    load_res = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = StCross;
        end
      end
      StCross: begin
        state_d = StDet;
      end
      StDet: begin
        cnt_d   = '0;
        state_d = StRun;
      end
      StRun: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!res_vld_q || res_ready_i) begin
          load_res = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Cross product of the second and third vertices.
  assign cp[0] = prod_t'($signed(item_q.p[1][1])) * prod_t'($signed(item_q.p[2][2]));
  assign cp[1] = prod_t'($signed(item_q.p[1][2])) * prod_t'($signed(item_q.p[2][1]));
  assign cp[2] = prod_t'($signed(item_q.p[1][2])) * prod_t'($signed(item_q.p[2][0]));
  assign cp[3] = prod_t'($signed(item_q.p[1][0])) * prod_t'($signed(item_q.p[2][2]));
  assign cp[4] = prod_t'($signed(item_q.p[1][0])) * prod_t'($signed(item_q.p[2][1]));
  assign cp[5] = prod_t'($signed(item_q.p[1][1])) * prod_t'($signed(item_q.p[2][0]));
  assign cross_d[0] = cross_t'(cp[0]) - cross_t'(cp[1]);
  assign cross_d[1] = cross_t'(cp[2]) - cross_t'(cp[3]);
  assign cross_d[2] = cross_t'(cp[4]) - cross_t'(cp[5]);

  // Triple product with the first vertex.
  assign dp[0] = dot_t'($signed(item_q.p[0][0])) * dot_t'(cross_q[0]);
  assign dp[1] = dot_t'($signed(item_q.p[0][1])) * dot_t'(cross_q[1]);
  assign dp[2] = dot_t'($signed(item_q.p[0][2])) * dot_t'(cross_q[2]);
  assign det_d = det_t'(dp[0]) + det_t'(dp[1]) + det_t'(dp[2]);

  // Factor for the accumulator in the first pipeline stage.
  assign fac_idx_d = cnt_q[AccIdxW-1:0];
  assign fac_vld_d = (state_q == StRun) && (cnt_q < CntW'(NumAcc));

  always_comb begin
    ax_r = AxisX;
    ax_c = AxisX;
    unique case (fac_idx_d)
      AccCovYy: begin
        ax_r = AxisY;
        ax_c = AxisY;
      end
      AccCovZz: begin
        ax_r = AxisZ;
        ax_c = AxisZ;
      end
      AccCovXy: begin
        ax_c = AxisY;
      end
      AccCovXz: begin
        ax_c = AxisZ;
      end
      AccCovYz: begin
        ax_r = AxisY;
        ax_c = AxisZ;
      end
      default: begin
        ax_r = AxisX;
        ax_c = AxisX;
      end
    endcase
  end

  assign pp0 = prod_t'($signed(item_q.p[0][ax_r])) * prod_t'($signed(item_q.p[0][ax_c]));
  assign pp1 = prod_t'($signed(item_q.p[1][ax_r])) * prod_t'($signed(item_q.p[1][ax_c]));
  assign pp2 = prod_t'($signed(item_q.p[2][ax_r])) * prod_t'($signed(item_q.p[2][ax_c]));
  assign ssq = ssq_t'($signed(item_q.s[ax_r])) * ssq_t'($signed(item_q.s[ax_c]));
  assign cov_fac = fac_t'(pp0) + fac_t'(pp1) + fac_t'(pp2) + fac_t'(ssq);

  always_comb begin
    unique case (fac_idx_d)
      AccCovXx, AccCovYy, AccCovZz, AccCovXy, AccCovXz, AccCovYz: begin
        fac_d = cov_fac;
      end
      AccDet: begin
        fac_d = fac_t'(1);
      end
      AccMomX: begin
        fac_d = fac_t'(item_q.s[0]);
      end
      AccMomY: begin
        fac_d = fac_t'(item_q.s[1]);
      end
      AccMomZ: begin
        fac_d = fac_t'(item_q.s[2]);
      end
      default: begin
        fac_d = '0;
      end
    endcase
  end

  // Second stage: one product of the triple product and the factor, at full width.
  assign term_d = acc_t'(det_q) * acc_t'(fac_q);

  // Third stage: add with clamping to the signed 64-bit range.
  assign wide_sum = {acc_q[term_idx_q][AccW-1], acc_q[term_idx_q]}
                  + {term_q[AccW-1], term_q};
  assign sat_hit  = (wide_sum[AccW] != wide_sum[AccW-1]);
  assign sat_val  = !sat_hit ? acc_t'(wide_sum) :
                    wide_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};

  // Data path registers without reset.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q == StCross) begin
      cross_q <= cross_d;
    end
    if (state_q == StDet) begin
      det_q <= det_d;
    end
    fac_q      <= fac_d;
    fac_idx_q  <= fac_idx_d;
    term_q     <= term_d;
    term_idx_q <= fac_idx_q;
    if (load_res) begin
      for (int i = 0; i < NumAcc; i++) begin
        res_q.acc[i] <= acc_q[i];
      end
      res_q.overflow <= ovf_q;
    end
  end

  // Control state, accumulators and the sticky overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      fac_vld_q  <= 1'b0;
      term_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      ovf_q      <= 1'b0;
      for (int i = 0; i < NumAcc; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fac_vld_q  <= fac_vld_d;
      term_vld_q <= fac_vld_q;
      if (load_res) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (state_q == StCross && item_q.restart) begin
        ovf_q <= 1'b0;
        for (int i = 0; i < NumAcc; i++) begin
          acc_q[i] <= '0;
        end
      end else if (term_vld_q) begin
        acc_q[term_idx_q] <= sat_val;
        if (sat_hit) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// File: design/polyhedron_mass_moment_accumulator_core.sv
// ----------------------------------------------------------------------------
// polyhedron_mass_moment_accumulator_core: polyhedron mass moment accumulator
// Each face passes the queue, then the back end's cross, triple product, run
// and output states; it takes a new face only once the last one's totals are
// loaded; ten accumulators share one 37 x 27 bit multiply and saturating add.
// Reset: asynchronous, clears all totals, the overflow flag and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyhedron_mass_moment_accumulator_core
  import pmma_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pmma_face_if.sink       face_i,
  pmma_result_if.source   result_o
);

  logic         push;
  logic         pop;
  pmma_item_t   front_item;
  pmma_item_t   queue_item;
  pmma_q_stat_t q_stat;
  pmma_result_t res;

  // Intake and classification.
  pmma_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .face_i   (face_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (front_item)
  );

  // Decoupling queue.
  pmma_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  // Accumulation back end.
  pmma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (queue_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  // Result fields in port order.
  assign result_o.cov_xx    = res.acc[AccCovXx];
  assign result_o.cov_yy    = res.acc[AccCovYy];
  assign result_o.cov_zz    = res.acc[AccCovZz];
  assign result_o.cov_xy    = res.acc[AccCovXy];
  assign result_o.cov_xz    = res.acc[AccCovXz];
  assign result_o.cov_yz    = res.acc[AccCovYz];
  assign result_o.det_total = res.acc[AccDet];
  assign result_o.moment_x  = res.acc[AccMomX];
  assign result_o.moment_y  = res.acc[AccMomY];
  assign result_o.moment_z  = res.acc[AccMomZ];
  assign result_o.overflow  = res.overflow;

  // The queue is never written while full.
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !push)
    else $error("face request written into a full queue");

  // The back end only takes an item that is present.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("back end read from an empty queue");

  // The back end works on one face at a time.
  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("back end took two faces in consecutive cycles");

endmodule

// File: verif/polyhedron_mass_moment_accumulator_core_tb.sv
// ----------------------------------------------------------------------------
// polyhedron_mass_moment_accumulator_core_tb: self-checking bench for the core
// Drives hull triangles into the face channel with bursty pacing and stalls
// the totals channel. A behavioural model of the saturating accumulators
// predicts the running totals of every accepted request, and each returned
// set of totals is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyhedron_mass_moment_accumulator_core_tb
  import pmma_pkg::*;
();

  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 32;
  localparam int NumCov      = 6;
  localparam int NumAxis     = 3;
  localparam int AxisX       = 0;
  localparam int AxisY       = 1;
  localparam int AxisZ       = 2;

  // Covariance slots with the axis pair that feeds each of them.
  localparam logic [AccIdxW-1:0] CovSlot [NumCov] =
    '{AccCovXx, AccCovYy, AccCovZz, AccCovXy, AccCovXz, AccCovYz};
  localparam int CovRow [NumCov] = '{AxisX, AxisY, AxisZ, AxisX, AxisX, AxisY};
  localparam int CovCol [NumCov] = '{AxisX, AxisY, AxisZ, AxisY, AxisZ, AxisZ};
  localparam logic [AccIdxW-1:0] MomSlot [NumAxis] = '{AccMomX, AccMomY, AccMomZ};

  // One face request: vertices indexed [vertex][axis], a = 0, b = 1, c = 2.
  typedef struct packed {
    logic              restart;
    coord_t [2:0][2:0] vtx;
  } face_req_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoinFlip,
    ReadyLongStalls
  } ready_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pmma_face_if   face_bus ();
  pmma_result_if result_bus ();

  polyhedron_mass_moment_accumulator_core #(
    .COORD_WIDTH(CoordWidthDef)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .face_i  (face_bus),
    .result_o(result_bus)
  );

  // Model of the accumulators and the queue of totals still owed.
  acc_t         totals_model [NumAcc];
  logic         overflow_model;
  pmma_result_t expected_totals_q [$];
  int           error_count   = 0;
  int           cycle_count   = 0;
  int           burst_left    = 1;
  int           gap_free_left = 0;

  string slot_name [NumAcc] = '{"cov_xx", "cov_yy", "cov_zz", "cov_xy", "cov_xz",
                                "cov_yz", "det_total", "moment_x", "moment_y",
                                "moment_z"};

  // Clock generation.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Adds one term to an accumulator, clamping to the signed 64-bit range.
  function automatic void add_saturating(input logic [AccIdxW-1:0] slot,
                                         input acc_t term);
    logic [AccW:0] wide;
    wide = {totals_model[slot][AccW-1], totals_model[slot]} + {term[AccW-1], term};
    if (wide[AccW] != wide[AccW-1]) begin
      overflow_model     = 1'b1;
      totals_model[slot] = wide[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                      : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      totals_model[slot] = wide[AccW-1:0];
    end
  endfunction

  // Folds one face into the model and returns the running totals it yields.
  function automatic pmma_result_t predict_totals(input face_req_t f);
    longint       p [3][NumAxis];
    longint       s [NumAxis];
    longint       det;
    longint       q;
    int           r;
    int           c;
    pmma_result_t res;
    if (f.restart) begin
      foreach (totals_model[j]) totals_model[j] = '0;
      overflow_model = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < NumAxis; k++) begin
        p[i][k] = longint'($signed(f.vtx[i][k]));
      end
    end
    for (int k = 0; k < NumAxis; k++) begin
      s[k] = p[0][k] + p[1][k] + p[2][k];
    end
    // Triple product a . (b x c).
    det = p[0][AxisX] * (p[1][AxisY] * p[2][AxisZ] - p[1][AxisZ] * p[2][AxisY])
        + p[0][AxisY] * (p[1][AxisZ] * p[2][AxisX] - p[1][AxisX] * p[2][AxisZ])
        + p[0][AxisZ] * (p[1][AxisX] * p[2][AxisY] - p[1][AxisY] * p[2][AxisX]);
    for (int n = 0; n < NumCov; n++) begin
      r = CovRow[n];
      c = CovCol[n];
      q = p[0][r] * p[0][c] + p[1][r] * p[1][c] + p[2][r] * p[2][c] + s[r] * s[c];
      add_saturating(CovSlot[n], det * q);
    end
    add_saturating(AccDet, det);
    for (int k = 0; k < NumAxis; k++) begin
      add_saturating(MomSlot[k], det * s[k]);
    end
    for (int j = 0; j < NumAcc; j++) begin
      res.acc[j] = totals_model[j];
    end
    res.overflow = overflow_model;
    return res;
  endfunction

  function automatic face_req_t make_face(input logic restart,
                                          input int ax, input int ay, input int az,
                                          input int bx, input int by, input int bz,
                                          input int cx, input int cy, input int cz);
    face_req_t f;
    f.restart      = restart;
    f.vtx[0][AxisX] = coord_t'(ax);
    f.vtx[0][AxisY] = coord_t'(ay);
    f.vtx[0][AxisZ] = coord_t'(az);
    f.vtx[1][AxisX] = coord_t'(bx);
    f.vtx[1][AxisY] = coord_t'(by);
    f.vtx[1][AxisZ] = coord_t'(bz);
    f.vtx[2][AxisX] = coord_t'(cx);
    f.vtx[2][AxisY] = coord_t'(cy);
    f.vtx[2][AxisZ] = coord_t'(cz);
    return f;
  endfunction

  // A magnitude of 2048 or more means the whole two's complement range.
  function automatic coord_t rand_coord(input int mag);
    if (mag >= 2048) begin
      return coord_t'($urandom);
    end
    return coord_t'(int'($urandom_range(0, 2 * mag)) - mag);
  endfunction

  // Presents one face request, waits for it to be taken and then paces the
  // sender: bursts of random length, random gaps, and gap-free stretches.
  task automatic send_face(input face_req_t f);
    int gap;
    face_bus.valid   <= 1'b1;
    face_bus.restart <= f.restart;
    face_bus.ax      <= f.vtx[0][AxisX];
    face_bus.ay      <= f.vtx[0][AxisY];
    face_bus.az      <= f.vtx[0][AxisZ];
    face_bus.bx      <= f.vtx[1][AxisX];
    face_bus.by      <= f.vtx[1][AxisY];
    face_bus.bz      <= f.vtx[1][AxisZ];
    face_bus.cx      <= f.vtx[2][AxisX];
    face_bus.cy      <= f.vtx[2][AxisY];
    face_bus.cz      <= f.vtx[2][AxisZ];
    do @(posedge clk_i); while (face_bus.ready !== 1'b1);
    expected_totals_q.push_back(predict_totals(f));
    if (burst_left > 0) burst_left--;
    if (gap_free_left > 0) gap_free_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_free_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          gap_free_left = $urandom_range(40, 120);
        end else begin
          gap = $urandom_range(1, 20);
          face_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Totals of the very first faces must start from the cleared state.
  task automatic test_first_face_from_reset();
    send_face(make_face(1'b0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_face(make_face(1'b0, 5, 0, 0, 0, 7, 0, 0, 0, 3));
  endtask

  // Swapping two vertices flips the sign of the triple product.
  task automatic test_orientation();
    send_face(make_face(1'b0, 1, 0, 0, 0, 0, 1, 0, 1, 0));
    send_face(make_face(1'b0, 5, 0, 0, 0, 0, 3, 0, 7, 0));
    send_face(make_face(1'b1, 3, -5, 7, -2, 9, 4, 6, 1, -8));
    send_face(make_face(1'b0, 3, -5, 7, 6, 1, -8, -2, 9, 4));
  endtask

  // Faces built from the most positive and most negative coordinates.
  task automatic test_coordinate_extremes();
    send_face(make_face(1'b1, 2047, -2048, -2048, -2048, 2047, -2048,
                        -2048, -2048, 2047));
    send_face(make_face(1'b0, 2047, -2048, -2048, -2048, -2048, 2047,
                        -2048, 2047, -2048));
    send_face(make_face(1'b0, 2047, 0, 0, 0, 2047, 0, 0, 0, 2047));
    send_face(make_face(1'b0, -2048, 0, 0, 0, -2048, 0, 0, 0, -2048));
    send_face(make_face(1'b0, 2047, -2048, 2047, -2048, 2047, -2048,
                        2047, 2047, -2048));
    send_face(make_face(1'b0, -2048, -2048, -2048, -2048, -2048, -2048,
                        -2048, -2048, -2048));
    send_face(make_face(1'b0, 2047, 2047, 2047, 2047, 2047, 2047,
                        2047, 2047, 2047));
  endtask

  // Degenerate triangles add nothing; a restart on one leaves all zero.
  task automatic test_degenerate_faces();
    send_face(make_face(1'b0, 0, 0, 0, 1500, -700, 33, -2048, 2047, 12));
    send_face(make_face(1'b0, 100, 200, 300, 200, 400, 600, -50, -100, -150));
    send_face(make_face(1'b0, -911, 402, 77, -911, 402, 77, 1234, -5, 2047));
    send_face(make_face(1'b1, 17, -3, 9, 17, -3, 9, 17, -3, 9));
  endtask

  // Well-formed hulls: a restart on the first face, then random faces whose
  // coordinate magnitude is chosen once per hull.
  task automatic test_random_hulls(input int face_budget);
    int        sent;
    int        len;
    int        mag;
    face_req_t f;
    sent = 0;
    while (sent < face_budget) begin
      len = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       mag = 15;
        1:       mag = 255;
        2:       mag = 1023;
        default: mag = 2048;
      endcase
      for (int n = 0; n < len; n++) begin
        f.restart = (n == 0);
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < NumAxis; k++) begin
            f.vtx[i][k] = rand_coord(mag);
          end
        end
        send_face(f);
        sent++;
      end
    end
  endtask

  // Large faces of one orientation drive the covariance sums into their clamp,
  // then the opposite orientation pulls them back through zero and into the
  // other clamp, so the sticky flag and the clamped adders are both exercised.
  task automatic test_saturating_runs(input int face_budget);
    int           sent;
    int           climb_len;
    int           total_len;
    int           r;
    logic         flip;
    face_req_t    f;
    coord_t [2:0] vb;
    sent = 0;
    while (sent < face_budget) begin
      flip      = 1'($urandom_range(0, 1));
      climb_len = $urandom_range(18, 30);
      total_len = climb_len + $urandom_range(10, 40);
      for (int n = 0; n < total_len; n++) begin
        f.restart = (n == 0);
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < NumAxis; k++) begin
            r = $urandom_range(0, 63);
            f.vtx[i][k] = coord_t'((i == k) ? 2047 - r : -2048 + r);
          end
        end
        if (((n < climb_len) ? 1'b1 : 1'b0) ^ flip) begin
          vb       = f.vtx[1];
          f.vtx[1] = f.vtx[2];
          f.vtx[2] = vb;
        end
        send_face(f);
        sent++;
      end
    end
  endtask

  // Loose faces with restarts at random and some repeated vertices.
  task automatic test_noise_faces(input int face_budget);
    face_req_t f;
    for (int n = 0; n < face_budget; n++) begin
      f.restart = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NumAxis; k++) begin
          f.vtx[i][k] = rand_coord(2048);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        f.vtx[1] = f.vtx[0];
      end
      send_face(f);
    end
  endtask

  // Lets the last totals drain, then reports the outcome.
  task automatic finish_run();
    face_bus.valid <= 1'b0;
    while (expected_totals_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("polyhedron_mass_moment_accumulator_core_tb: done, clean");
    end else begin
      $display("polyhedron_mass_moment_accumulator_core_tb: done, errors");
    end
    $finish;
  endtask

  // Test sequence.
  initial begin : test_sequence
    foreach (totals_model[j]) totals_model[j] = '0;
    overflow_model   = 1'b0;
    face_bus.valid   <= 1'b0;
    face_bus.restart <= 1'b0;
    face_bus.ax      <= '0;
    face_bus.ay      <= '0;
    face_bus.az      <= '0;
    face_bus.bx      <= '0;
    face_bus.by      <= '0;
    face_bus.bz      <= '0;
    face_bus.cx      <= '0;
    face_bus.cy      <= '0;
    face_bus.cz      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_face_from_reset();
    test_orientation();
    test_coordinate_extremes();
    test_degenerate_faces();
    test_random_hulls(900);
    test_saturating_runs(260);
    test_noise_faces(140);
    finish_run();
  end

  // Receiver pacing: modes of random length with no stalls, coin-flip stalls
  // or long stall runs.
  initial begin : result_pacing
    ready_mode_e mode;
    int          mode_left;
    int          run_left;
    logic        level;
    mode      = ReadyAlways;
    mode_left = 0;
    run_left  = 0;
    level     = 1'b1;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        ReadyAlways: begin
          result_bus.ready <= 1'b1;
        end
        ReadyCoinFlip: begin
          result_bus.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (run_left == 0) begin
            level    = ~level;
            run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 40);
          end
          run_left--;
          result_bus.ready <= level;
        end
      endcase
    end
  end

  // Compares every accepted set of totals with the oldest prediction.
  always @(posedge clk_i) begin : totals_check
    acc_t         seen [NumAcc];
    pmma_result_t want;
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      seen[AccCovXx] = result_bus.cov_xx;
      seen[AccCovYy] = result_bus.cov_yy;
      seen[AccCovZz] = result_bus.cov_zz;
      seen[AccCovXy] = result_bus.cov_xy;
      seen[AccCovXz] = result_bus.cov_xz;
      seen[AccCovYz] = result_bus.cov_yz;
      seen[AccDet]   = result_bus.det_total;
      seen[AccMomX]  = result_bus.moment_x;
      seen[AccMomY]  = result_bus.moment_y;
      seen[AccMomZ]  = result_bus.moment_z;
      if (expected_totals_q.size() == 0) begin
        error_count++;
        $display("%0t: totals returned with no face request outstanding", $time);
      end else begin
        want = expected_totals_q.pop_front();
        for (int j = 0; j < NumAcc; j++) begin
          if (seen[j] !== want.acc[j]) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                     slot_name[j], $signed(want.acc[j]), seen[j]);
          end
        end
        if (result_bus.overflow !== want.overflow) begin
          error_count++;
          $display("%0t: overflow mismatch, expected %0b, got %0b", $time,
                   want.overflow, result_bus.overflow);
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("polyhedron_mass_moment_accumulator_core_tb: done, errors");
    $finish;
  end

endmodule
